>>> sv/square_to_disc_warp_address_unit_assert.svh
// Assertion shorthands for the warp address unit; clk and rst_n must be in scope.
`ifndef SQUARE_TO_DISC_WARP_ADDRESS_UNIT_ASSERT_SVH
`define SQUARE_TO_DISC_WARP_ADDRESS_UNIT_ASSERT_SVH

// same-cycle implication
`define SDW_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdw assertion failed");

// next-cycle implication
`define SDW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdw assertion failed");

`endif

>>> sv/sdw_pkg.sv
`default_nettype none
package sdw_pkg;

    localparam int CFG_W          = 13;
    localparam int HALF_W         = CFG_W - 1;
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

endpackage
`default_nettype wire

>>> sv/sdw_if.sv
`default_nettype none
interface sdw_in_if #(
    parameter int COORD_BITS = sdw_pkg::COORD_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] out_col;
    logic [COORD_BITS-1:0] out_row;

    modport source (output valid, output out_col, output out_row, input ready);
    modport sink   (input valid, input out_col, input out_row, output ready);
endinterface

interface sdw_out_if #(
    parameter int COORD_BITS = sdw_pkg::COORD_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] src_col;
    logic [COORD_BITS-1:0] src_row;
    logic                  keep_self;
    logic                  clipped;

    modport source (output valid, output src_col, output src_row, output keep_self,
                    output clipped, input ready);
    modport sink   (input valid, input src_col, input src_row, input keep_self,
                    input clipped, output ready);
endinterface
`default_nettype wire

>>> sv/sdw_div_cell.sv
`default_nettype none
// One restoring-division step on two lanes, one quotient bit per cell.
module sdw_div_cell #(
    parameter int DW = 12,
    parameter int NW = 17,
    parameter int QW = 17,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_div_x,
    input  logic [DW-1:0] in_div_y,
    input  logic [DW-1:0] in_rem_x,
    input  logic [DW-1:0] in_rem_y,
    input  logic [NW-1:0] in_num_x,
    input  logic [NW-1:0] in_num_y,
    input  logic [QW-1:0] in_quo_x,
    input  logic [QW-1:0] in_quo_y,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [DW-1:0] out_div_x,
    output logic [DW-1:0] out_div_y,
    output logic [DW-1:0] out_rem_x,
    output logic [DW-1:0] out_rem_y,
    output logic [NW-1:0] out_num_x,
    output logic [NW-1:0] out_num_y,
    output logic [QW-1:0] out_quo_x,
    output logic [QW-1:0] out_quo_y,
    output logic [SW-1:0] out_side
);
    logic          valid_reg;
    logic [DW-1:0] div_x_reg, div_y_reg, rem_x_reg, rem_y_reg;
    logic [NW-1:0] num_x_reg, num_y_reg;
    logic [QW-1:0] quo_x_reg, quo_y_reg;
    logic [SW-1:0] side_reg;

    logic [DW:0]   t_x, t_y, d_x, d_y;
    logic          ge_x, ge_y;
    logic [DW-1:0] rem_x_next, rem_y_next;
    logic [NW-1:0] num_x_next, num_y_next;
    logic [QW-1:0] quo_x_next, quo_y_next;

    always_comb
    begin
        t_x  = {in_rem_x, in_num_x[NW-1]};
        t_y  = {in_rem_y, in_num_y[NW-1]};
        d_x  = t_x - {1'b0, in_div_x};
        d_y  = t_y - {1'b0, in_div_y};
        ge_x = t_x >= {1'b0, in_div_x};
        ge_y = t_y >= {1'b0, in_div_y};
        rem_x_next = ge_x ? d_x[DW-1:0] : t_x[DW-1:0];
        rem_y_next = ge_y ? d_y[DW-1:0] : t_y[DW-1:0];
        num_x_next = {in_num_x[NW-2:0], 1'b0};
        num_y_next = {in_num_y[NW-2:0], 1'b0};
        quo_x_next = {in_quo_x[QW-2:0], ge_x};
        quo_y_next = {in_quo_y[QW-2:0], ge_y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_x_reg <= in_div_x;
            div_y_reg <= in_div_y;
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
            num_x_reg <= num_x_next;
            num_y_reg <= num_y_next;
            quo_x_reg <= quo_x_next;
            quo_y_reg <= quo_y_next;
            side_reg  <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_div_x = div_x_reg;
    assign out_div_y = div_y_reg;
    assign out_rem_x = rem_x_reg;
    assign out_rem_y = rem_y_reg;
    assign out_num_x = num_x_reg;
    assign out_num_y = num_y_reg;
    assign out_quo_x = quo_x_reg;
    assign out_quo_y = quo_y_reg;
    assign out_side  = side_reg;
endmodule
`default_nettype wire

>>> sv/sdw_sqrt_cell.sv
`default_nettype none
// One digit-by-digit square root step: two radicand bits in, one root bit out.
module sdw_sqrt_cell #(
    parameter int SQW = 34,
    parameter int RTW = 17,
    parameter int PW  = 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [SQW-1:0] in_s,
    input  logic [RTW-1:0] in_root,
    input  logic [RTW:0]   in_rem,
    input  logic [PW-1:0]  in_pay,
    output logic           out_valid,
    output logic [SQW-1:0] out_s,
    output logic [RTW-1:0] out_root,
    output logic [RTW:0]   out_rem,
    output logic [PW-1:0]  out_pay
);
    logic           valid_reg;
    logic [SQW-1:0] s_reg;
    logic [RTW-1:0] root_reg;
    logic [RTW:0]   rem_reg;
    logic [PW-1:0]  pay_reg;

    logic [RTW+2:0] t, trial, diff;
    logic           ge;
    logic [SQW-1:0] s_next;
    logic [RTW-1:0] root_next;
    logic [RTW:0]   rem_next;

    always_comb
    begin
        t         = {in_rem, in_s[SQW-1:SQW-2]};
        trial     = {1'b0, in_root, 2'b01};
        diff      = t - trial;
        ge        = t >= trial;
        rem_next  = ge ? diff[RTW:0] : t[RTW:0];
        root_next = {in_root[RTW-2:0], ge};
        s_next    = {in_s[SQW-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg    <= s_next;
            root_reg <= root_next;
            rem_reg  <= rem_next;
            pay_reg  <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_s     = s_reg;
    assign out_root  = root_reg;
    assign out_rem   = rem_reg;
    assign out_pay   = pay_reg;
endmodule
`default_nettype wire

>>> sv/square_to_disc_warp_address_unit.sv
`default_nettype none
// Throughput: one item per cycle while the output buffer is not full; every stage of the
// cell chains then takes a new item each cycle.
// Depth is set by the two divider chains (one quotient bit per cell) and the root chain.
// A two-entry output buffer keeps input ready registered; a full buffer stalls the chain.
// Reset: asynchronous, active low; clears valid bits and buffer, frame size 640 x 480.
`include "square_to_disc_warp_address_unit_assert.svh"
module square_to_disc_warp_address_unit #(
    parameter int COORD_BITS = sdw_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sdw_pkg::FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  sdw_pkg::cfg_reg_t        cfg_index,
    input  logic [sdw_pkg::CFG_W-1:0] cfg_data,
    sdw_in_if.sink                   pix_in,
    sdw_out_if.source                addr_out
);
    import sdw_pkg::*;

    localparam int EW   = (COORD_BITS > HALF_W) ? COORD_BITS : HALF_W;
    localparam int UW   = FRAC_BITS + 1;              // relX, relY, root
    localparam int SQW  = 2 * UW;                     // sum of squares
    localparam int BMW  = HALF_W + UW;                // b * m
    localparam int NXW  = BMW + UW;                   // b * m * rel
    localparam int QW2  = HALF_W + FRAC_BITS;         // offset
    localparam int SBW  = 2 * COORD_BITS + 3;         // col, row, centre, signs
    localparam int PW   = 2 * NXW + SBW;
    localparam int SB2W = SBW + 1;
    localparam int D1N  = UW;
    localparam int RTN  = UW;
    localparam int D2N  = QW2;
    localparam int VW   = (COORD_BITS > HALF_W + 1) ? COORD_BITS : HALF_W + 1;
    localparam int RW   = 2 * COORD_BITS + 2;
    localparam logic [VW-1:0] CMAX = VW'((64'd1 << COORD_BITS) - 64'd1);

    // configuration
    logic [CFG_W-1:0]  fw_reg, fh_reg;
    logic [HALF_W-1:0] half_a, half_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= FRAME_WIDTH_RST;
            fh_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  fw_reg <= cfg_data;
                REG_FRAME_HEIGHT: fh_reg <= cfg_data;
                default:          fw_reg <= fw_reg;
            endcase
        end
    end

    assign half_a = (fw_reg[CFG_W-1:1] == '0) ? HALF_W'(1) : fw_reg[CFG_W-1:1];
    assign half_b = (fh_reg[CFG_W-1:1] == '0) ? HALF_W'(1) : fh_reg[CFG_W-1:1];

    // output buffer control
    logic [1:0] fifo_cnt_reg, fifo_cnt_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic       pipe_en, push, pop;

    assign pipe_en      = fifo_cnt_reg != 2'd2;
    assign pix_in.ready = pipe_en;

    // front stage: offsets from the centre
    logic [EW-1:0]         col_e, row_e, a_e, b_e, dfx, dfy;
    logic                  negx_c, negy_c;
    logic [HALF_W-1:0]     dx_c, dy_c;
    logic                  f_valid_reg;
    logic [HALF_W-1:0]     f_dx_reg, f_dy_reg;
    logic [SBW-1:0]        f_side_reg;

    always_comb
    begin
        col_e  = EW'(pix_in.out_col);
        row_e  = EW'(pix_in.out_row);
        a_e    = EW'(half_a);
        b_e    = EW'(half_b);
        negx_c = col_e < a_e;
        negy_c = row_e < b_e;
        dfx    = negx_c ? a_e - col_e : col_e - a_e;
        dfy    = negy_c ? b_e - row_e : row_e - b_e;
        dx_c   = (dfx > a_e) ? half_a : dfx[HALF_W-1:0];
        dy_c   = (dfy > b_e) ? half_b : dfy[HALF_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else if (pipe_en)
            f_valid_reg <= pix_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            f_dx_reg   <= dx_c;
            f_dy_reg   <= dy_c;
            f_side_reg <= {pix_in.out_col, pix_in.out_row,
                           (dx_c == '0) && (dy_c == '0), negx_c, negy_c};
        end
    end

    // relX = dx / a, relY = dy / b
    logic              d1_valid [0:D1N];
    logic [HALF_W-1:0] d1_div_x [0:D1N];
    logic [HALF_W-1:0] d1_div_y [0:D1N];
    logic [HALF_W-1:0] d1_rem_x [0:D1N];
    logic [HALF_W-1:0] d1_rem_y [0:D1N];
    logic [UW-1:0]     d1_num_x [0:D1N];
    logic [UW-1:0]     d1_num_y [0:D1N];
    logic [UW-1:0]     d1_quo_x [0:D1N];
    logic [UW-1:0]     d1_quo_y [0:D1N];
    logic [SBW-1:0]    d1_side  [0:D1N];

    assign d1_valid[0] = f_valid_reg;
    assign d1_div_x[0] = half_a;
    assign d1_div_y[0] = half_b;
    // top dividend bits are below the divisor, so they start as remainder
    assign d1_rem_x[0] = {1'b0, f_dx_reg[HALF_W-1:1]};
    assign d1_rem_y[0] = {1'b0, f_dy_reg[HALF_W-1:1]};
    assign d1_num_x[0] = {f_dx_reg[0], {FRAC_BITS{1'b0}}};
    assign d1_num_y[0] = {f_dy_reg[0], {FRAC_BITS{1'b0}}};
    assign d1_quo_x[0] = '0;
    assign d1_quo_y[0] = '0;
    assign d1_side[0]  = f_side_reg;

    for (genvar i = 0; i < D1N; i++)
    begin : g_div1
        sdw_div_cell #(
            .DW (HALF_W),
            .NW (UW),
            .QW (UW),
            .SW (SBW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (pipe_en),
            .in_valid  (d1_valid[i]),
            .in_div_x  (d1_div_x[i]),
            .in_div_y  (d1_div_y[i]),
            .in_rem_x  (d1_rem_x[i]),
            .in_rem_y  (d1_rem_y[i]),
            .in_num_x  (d1_num_x[i]),
            .in_num_y  (d1_num_y[i]),
            .in_quo_x  (d1_quo_x[i]),
            .in_quo_y  (d1_quo_y[i]),
            .in_side   (d1_side[i]),
            .out_valid (d1_valid[i+1]),
            .out_div_x (d1_div_x[i+1]),
            .out_div_y (d1_div_y[i+1]),
            .out_rem_x (d1_rem_x[i+1]),
            .out_rem_y (d1_rem_y[i+1]),
            .out_num_x (d1_num_x[i+1]),
            .out_num_y (d1_num_y[i+1]),
            .out_quo_x (d1_quo_x[i+1]),
            .out_quo_y (d1_quo_y[i+1]),
            .out_side  (d1_side[i+1])
        );
    end

    // products
    logic [UW-1:0]  ux, uy, mq;
    logic           m1_valid_reg, m2_valid_reg;
    logic [SQW-1:0] m1_px_reg, m1_py_reg, m2_s_reg;
    logic [BMW-1:0] m1_bm_reg;
    logic [UW-1:0]  m1_ux_reg, m1_uy_reg;
    logic [SBW-1:0] m1_side_reg, m2_side_reg;
    logic [NXW-1:0] m2_nx_reg, m2_ny_reg;

    assign ux = d1_quo_x[D1N];
    assign uy = d1_quo_y[D1N];
    assign mq = (ux > uy) ? ux : uy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            m1_valid_reg <= d1_valid[D1N];
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            m1_px_reg   <= SQW'(ux) * SQW'(ux);
            m1_py_reg   <= SQW'(uy) * SQW'(uy);
            m1_bm_reg   <= BMW'(half_b) * BMW'(mq);
            m1_ux_reg   <= ux;
            m1_uy_reg   <= uy;
            m1_side_reg <= d1_side[D1N];
            m2_s_reg    <= m1_px_reg + m1_py_reg;
            m2_nx_reg   <= NXW'(m1_bm_reg) * NXW'(m1_ux_reg);
            m2_ny_reg   <= NXW'(m1_bm_reg) * NXW'(m1_uy_reg);
            m2_side_reg <= m1_side_reg;
        end
    end

    // r = sqrt(relX^2 + relY^2)
    logic           rt_valid [0:RTN];
    logic [SQW-1:0] rt_s     [0:RTN];
    logic [UW-1:0]  rt_root  [0:RTN];
    logic [UW:0]    rt_rem   [0:RTN];
    logic [PW-1:0]  rt_pay   [0:RTN];

    assign rt_valid[0] = m2_valid_reg;
    assign rt_s[0]     = m2_s_reg;
    assign rt_root[0]  = '0;
    assign rt_rem[0]   = '0;
    assign rt_pay[0]   = {m2_nx_reg, m2_ny_reg, m2_side_reg};

    for (genvar i = 0; i < RTN; i++)
    begin : g_sqrt
        sdw_sqrt_cell #(
            .SQW (SQW),
            .RTW (UW),
            .PW  (PW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (pipe_en),
            .in_valid  (rt_valid[i]),
            .in_s      (rt_s[i]),
            .in_root   (rt_root[i]),
            .in_rem    (rt_rem[i]),
            .in_pay    (rt_pay[i]),
            .out_valid (rt_valid[i+1]),
            .out_s     (rt_s[i+1]),
            .out_root  (rt_root[i+1]),
            .out_rem   (rt_rem[i+1]),
            .out_pay   (rt_pay[i+1])
        );
    end

    // offset = b * m * rel / r
    logic [UW-1:0]  rq;
    logic [NXW-1:0] nx, ny;

    assign rq = rt_root[RTN];
    assign nx = rt_pay[RTN][PW-1 -: NXW];
    assign ny = rt_pay[RTN][PW-1-NXW -: NXW];

    logic            d2_valid [0:D2N];
    logic [UW-1:0]   d2_div_x [0:D2N];
    logic [UW-1:0]   d2_div_y [0:D2N];
    logic [UW-1:0]   d2_rem_x [0:D2N];
    logic [UW-1:0]   d2_rem_y [0:D2N];
    logic [QW2-1:0]  d2_num_x [0:D2N];
    logic [QW2-1:0]  d2_num_y [0:D2N];
    logic [QW2-1:0]  d2_quo_x [0:D2N];
    logic [QW2-1:0]  d2_quo_y [0:D2N];
    logic [SB2W-1:0] d2_side  [0:D2N];

    // quotient fits QW2 bits, so the upper dividend bits stay below r;
    // a zero radius gives garbage here and is overridden at the end
    assign d2_valid[0] = rt_valid[RTN];
    assign d2_div_x[0] = rq;
    assign d2_div_y[0] = rq;
    assign d2_rem_x[0] = nx[QW2 +: UW];
    assign d2_rem_y[0] = ny[QW2 +: UW];
    assign d2_num_x[0] = nx[QW2-1:0];
    assign d2_num_y[0] = ny[QW2-1:0];
    assign d2_quo_x[0] = '0;
    assign d2_quo_y[0] = '0;
    assign d2_side[0]  = {rq == '0, rt_pay[RTN][SBW-1:0]};

    for (genvar i = 0; i < D2N; i++)
    begin : g_div2
        sdw_div_cell #(
            .DW (UW),
            .NW (QW2),
            .QW (QW2),
            .SW (SB2W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (pipe_en),
            .in_valid  (d2_valid[i]),
            .in_div_x  (d2_div_x[i]),
            .in_div_y  (d2_div_y[i]),
            .in_rem_x  (d2_rem_x[i]),
            .in_rem_y  (d2_rem_y[i]),
            .in_num_x  (d2_num_x[i]),
            .in_num_y  (d2_num_y[i]),
            .in_quo_x  (d2_quo_x[i]),
            .in_quo_y  (d2_quo_y[i]),
            .in_side   (d2_side[i]),
            .out_valid (d2_valid[i+1]),
            .out_div_x (d2_div_x[i+1]),
            .out_div_y (d2_div_y[i+1]),
            .out_rem_x (d2_rem_x[i+1]),
            .out_rem_y (d2_rem_y[i+1]),
            .out_num_x (d2_num_x[i+1]),
            .out_num_y (d2_num_y[i+1]),
            .out_quo_x (d2_quo_x[i+1]),
            .out_quo_y (d2_quo_y[i+1]),
            .out_side  (d2_side[i+1])
        );
    end

    // placement about the centre with saturation
    function automatic logic [COORD_BITS:0] place_f(
        input logic [HALF_W-1:0] half,
        input logic [QW2-1:0]    off,
        input logic              neg
    );
        logic [QW2-1:0] base;
        logic [QW2:0]   sum;
        logic [VW-1:0]  v;
        logic           clip;
        base = {half, {FRAC_BITS{1'b0}}};
        clip = 1'b0;
        if (neg)
        begin
            sum  = {1'b0, base - off};
            clip = off > base;
        end
        else
            sum = {1'b0, base} + {1'b0, off};
        v = VW'(sum >> FRAC_BITS);
        if (clip)
            v = '0;
        else if (v > CMAX)
            v = CMAX;
        return {clip, v[COORD_BITS-1:0]};
    endfunction

    logic [SB2W-1:0]       fin_side;
    logic                  rq_zero, centre, negx, negy;
    logic [COORD_BITS-1:0] in_col, in_row;
    logic [QW2-1:0]        ox, oy;
    logic [COORD_BITS:0]   px_res, py_res;
    logic [RW-1:0]         res;

    always_comb
    begin
        fin_side = d2_side[D2N];
        rq_zero  = fin_side[SB2W-1];
        in_col   = fin_side[SBW-1 -: COORD_BITS];
        in_row   = fin_side[SBW-1-COORD_BITS -: COORD_BITS];
        centre   = fin_side[2];
        negx     = fin_side[1];
        negy     = fin_side[0];
        ox       = rq_zero ? '0 : d2_quo_x[D2N];
        oy       = rq_zero ? '0 : d2_quo_y[D2N];
        px_res   = place_f(half_a, ox, negx);
        py_res   = place_f(half_b, oy, negy);
        if (centre)
            res = {in_col, in_row, 1'b1, 1'b0};
        else
            res = {px_res[COORD_BITS-1:0], py_res[COORD_BITS-1:0], 1'b0,
                   px_res[COORD_BITS] | py_res[COORD_BITS]};
    end

    // two-entry output buffer
    logic [RW-1:0] fifo_q_reg [2];

    assign push = d2_valid[D2N] && pipe_en;
    assign pop  = (fifo_cnt_reg != 2'd0) && addr_out.ready;

    always_comb
    begin
        case ({push, pop})
            2'b10:   fifo_cnt_next = fifo_cnt_reg + 2'd1;
            2'b01:   fifo_cnt_next = fifo_cnt_reg - 2'd1;
            default: fifo_cnt_next = fifo_cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_cnt_reg <= 2'd0;
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
        end
        else
        begin
            fifo_cnt_reg <= fifo_cnt_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_q_reg[wr_ptr_reg] <= res;
    end

    assign addr_out.valid = fifo_cnt_reg != 2'd0;
    assign {addr_out.src_col, addr_out.src_row, addr_out.keep_self, addr_out.clipped} =
        fifo_q_reg[rd_ptr_reg];

    `SDW_ASSERT_IMPLY(a_no_accept_when_full, pix_in.valid && pix_in.ready, fifo_cnt_reg != 2'd2)
    `SDW_ASSERT_IMPLY(a_cnt_range, rst_n, fifo_cnt_reg != 2'd3)
    `SDW_ASSERT_IMPLY(a_centre_no_clip, addr_out.valid && addr_out.keep_self, !addr_out.clipped)
    `SDW_ASSERT_NEXT(a_full_holds, fifo_cnt_reg == 2'd2 && !addr_out.ready, fifo_cnt_reg == 2'd2)
endmodule
`default_nettype wire

>>> tb/square_to_disc_warp_address_unit_tb.sv
`default_nettype none
module square_to_disc_warp_address_unit_tb;
    import sdw_pkg::*;

    typedef struct packed {
        logic [11:0] src_col;
        logic [11:0] src_row;
        logic        keep_self;
        logic        clipped;
    } warp_addr_t;

    typedef struct {
        bit         is_cfg;
        int         arg0;
        int         arg1;
        bit         typed;
        warp_addr_t result;
    } dir_row_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    cfg_reg_t         cfg_index;
    logic [CFG_W-1:0] cfg_data;

    sdw_in_if  pix_in ();
    sdw_out_if addr_out ();

    square_to_disc_warp_address_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pix_in),
        .addr_out  (addr_out)
    );

    logic [CFG_W-1:0] frame_w;
    logic [CFG_W-1:0] frame_h;
    warp_addr_t       addr_q[$];
    dir_row_t         dir_rows[$];
    int               src_idle;
    int               dst_idle;
    int               errors;
    int               n_sent;
    int               n_checked;
    int               n_keep;
    int               n_clip;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("square_to_disc_warp_address_unit regression: fail");
        $finish;
    end

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned t;
        res = 0;
        for (int i = 31; i >= 0; i--)
        begin
            t = res | (64'd1 << i);
            if (t * t <= v)
                res = t;
        end
        return res;
    endfunction

    function automatic logic [11:0] place_coord(longint unsigned half, longint unsigned off,
                                                bit neg, output bit clip);
        longint unsigned base;
        longint unsigned v;
        clip = 1'b0;
        base = half << 16;
        if (neg)
        begin
            if (off > base)
            begin
                clip = 1'b1;
                return 12'd0;
            end
            v = (base - off) >> 16;
        end
        else
            v = (base + off) >> 16;
        return (v > 64'd4095) ? 12'd4095 : v[11:0];
    endfunction

    function automatic warp_addr_t predict_source(logic [11:0] col, logic [11:0] row);
        longint unsigned a, b, dx, dy, ux, uy, mq, rq, ox, oy;
        bit nx, ny, cx, cy;
        warp_addr_t r;
        a = frame_w >> 1;
        b = frame_h >> 1;
        if (a == 0)
            a = 1;
        if (b == 0)
            b = 1;
        nx = col < a;
        dx = nx ? a - col : col - a;
        if (dx > a)
            dx = a;
        ny = row < b;
        dy = ny ? b - row : row - b;
        if (dy > b)
            dy = b;
        if (dx == 0 && dy == 0)
        begin
            r = '{col, row, 1'b1, 1'b0};
            return r;
        end
        ux = (dx << 16) / a;
        uy = (dy << 16) / b;
        mq = (ux > uy) ? ux : uy;
        rq = floor_sqrt(ux * ux + uy * uy);
        ox = 0;
        oy = 0;
        if (rq != 0)
        begin
            ox = (b * mq * ux) / rq;
            oy = (b * mq * uy) / rq;
        end
        r.src_col   = place_coord(a, ox, nx, cx);
        r.src_row   = place_coord(b, oy, ny, cy);
        r.keep_self = 1'b0;
        r.clipped   = cx | cy;
        return r;
    endfunction

    task automatic wait_drained();
        while (addr_q.size() != 0)
            @(posedge clk);
    endtask

    // pipeline is ~66 deep; let it empty before touching the frame size
    task automatic set_frame(int w, int h);
        wait_drained();
        repeat (72) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= w[CFG_W-1:0];
        @(negedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= h[CFG_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        frame_w = w[CFG_W-1:0];
        frame_h = h[CFG_W-1:0];
    endtask

    // entered at a falling edge, returns at a falling edge after the transfer
    task automatic send_pixel(logic [11:0] col, logic [11:0] row, bit typed, warp_addr_t res);
        while ($urandom_range(99) < src_idle)
        begin
            pix_in.valid <= 1'b0;
            @(negedge clk);
        end
        pix_in.valid   <= 1'b1;
        pix_in.out_col <= col;
        pix_in.out_row <= row;
        @(posedge clk);
        while (!pix_in.ready)
            @(posedge clk);
        addr_q.push_back(typed ? res : predict_source(col, row));
        n_sent++;
        @(negedge clk);
    endtask

    always @(negedge clk)
        addr_out.ready <= rst_n && ($urandom_range(99) >= dst_idle);

    always @(posedge clk)
    begin
        warp_addr_t e;
        if (rst_n && addr_out.valid && addr_out.ready)
        begin
            if (addr_q.size() == 0)
            begin
                $error("result transfer with nothing expected");
                errors++;
            end
            else
            begin
                e = addr_q.pop_front();
                n_checked++;
                if (addr_out.keep_self)
                    n_keep++;
                if (addr_out.clipped)
                    n_clip++;
                if (addr_out.src_col !== e.src_col)
                begin
                    $error("src_col: expected %0d, got %0d", e.src_col, addr_out.src_col);
                    errors++;
                end
                if (addr_out.src_row !== e.src_row)
                begin
                    $error("src_row: expected %0d, got %0d", e.src_row, addr_out.src_row);
                    errors++;
                end
                if (addr_out.keep_self !== e.keep_self)
                begin
                    $error("keep_self: expected %0b, got %0b", e.keep_self,
                           addr_out.keep_self);
                    errors++;
                end
                if (addr_out.clipped !== e.clipped)
                begin
                    $error("clipped: expected %0b, got %0b", e.clipped, addr_out.clipped);
                    errors++;
                end
            end
        end
    end

    function automatic void pix_row(int c, int r);
        dir_rows.push_back('{1'b0, c, r, 1'b0, '0});
    endfunction

    function automatic void typed_row(int c, int r, int sc, int sr, bit k, bit cl);
        warp_addr_t e;
        e = '{sc[11:0], sr[11:0], k, cl};
        dir_rows.push_back('{1'b0, c, r, 1'b1, e});
    endfunction

    function automatic void cfg_row(int w, int h);
        dir_rows.push_back('{1'b1, w, h, 1'b0, '0});
    endfunction

    initial
    begin
        int w, h, cmax, rmax, c, r;
        int frames[7][2];
        frames = '{'{640, 480}, '{4096, 4096}, '{2, 2}, '{8191, 8191},
                   '{1, 4096}, '{100, 4000}, '{0, 0}};
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_FRAME_WIDTH;
        cfg_data       = '0;
        pix_in.valid   = 1'b0;
        pix_in.out_col = '0;
        pix_in.out_row = '0;
        addr_out.ready = 1'b0;
        frame_w = FRAME_WIDTH_RST;
        frame_h = FRAME_HEIGHT_RST;
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        n_keep = 0;
        n_clip = 0;
        src_idle = 19;
        dst_idle = 61;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset frame size first
        typed_row(320, 240, 320, 240, 1'b1, 1'b0);
        pix_row(0, 0);
        pix_row(639, 479);
        pix_row(4095, 4095);
        pix_row(0, 4095);
        pix_row(4095, 0);
        pix_row(321, 240);
        pix_row(320, 241);
        pix_row(0, 240);
        pix_row(320, 0);
        // tall narrow frame: column offset overshoots left edge
        cfg_row(2, 4096);
        typed_row(0, 2048, 0, 2048, 1'b0, 1'b1);
        typed_row(1, 2048, 1, 2048, 1'b1, 1'b0);
        pix_row(0, 0);
        pix_row(4095, 4095);
        // zero size: half sizes forced to one
        cfg_row(0, 0);
        typed_row(1, 1, 1, 1, 1'b1, 1'b0);
        pix_row(0, 0);
        pix_row(4095, 4095);
        cfg_row(8191, 3);
        typed_row(4095, 1, 4095, 1, 1'b1, 1'b0);
        pix_row(0, 0);
        pix_row(4095, 4095);
        cfg_row(4096, 2);
        pix_row(4095, 0);
        pix_row(0, 1);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
            begin
                pix_in.valid <= 1'b0;
                set_frame(dir_rows[i].arg0, dir_rows[i].arg1);
            end
            else
                send_pixel(dir_rows[i].arg0[11:0], dir_rows[i].arg1[11:0],
                           dir_rows[i].typed, dir_rows[i].result);
        end

        for (int p = 0; p < 7; p++)
        begin
            if (p == 6)
            begin
                w = 2 * $urandom_range(1, 2048);
                h = 2 * $urandom_range(1, 2048);
            end
            else
            begin
                w = frames[p][0];
                h = frames[p][1];
            end
            pix_in.valid <= 1'b0;
            set_frame(w, h);
            case (p * 3 / 7)
                0: begin src_idle = 19; dst_idle = 61; end
                1: begin src_idle = 61; dst_idle = 19; end
                default: begin src_idle = 0; dst_idle = 0; end
            endcase
            cmax = (w < 1) ? 0 : ((w - 1 > 4095) ? 4095 : w - 1);
            rmax = (h < 1) ? 0 : ((h - 1 > 4095) ? 4095 : h - 1);
            for (int n = 0; n < 250; n++)
            begin
                if (p == 1 && n == 125)
                begin
                    pix_in.valid <= 1'b0;
                    wait_drained();
                    @(negedge clk);
                end
                case ($urandom_range(9))
                    0: begin c = $urandom_range(4095); r = $urandom_range(4095); end
                    1: begin c = (frame_w >> 1); r = (frame_h >> 1); end
                    2: begin c = $urandom_range(1) ? 0 : cmax; r = $urandom_range(rmax); end
                    default: begin c = $urandom_range(cmax); r = $urandom_range(rmax); end
                endcase
                send_pixel(c[11:0], r[11:0], 1'b0, '0);
            end
        end
        pix_in.valid <= 1'b0;

        wait_drained();
        repeat (80) @(posedge clk);
        $display("covered %0d transfers over many frame sizes incl. zero, odd and 8191",
                 n_sent);
        $display("checked %0d results: %0d centre pixels, %0d clipped", n_checked, n_keep,
                 n_clip);
        if (errors == 0 && addr_q.size() == 0)
            $display("square_to_disc_warp_address_unit regression: pass");
        else
            $display("square_to_disc_warp_address_unit regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
